FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the resampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define QCB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qcb assertion failed");

// Antecedent implies consequent in the next cycle.
`define QCB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qcb assertion failed");

`endif

FILE: rtl/core/qcb_pkg.sv
// Types and constants of the quad crop bilinear resampler.
package qcb_pkg;

  localparam int N_W        = 10;            // row, column and source index fields
  localparam int CH_W       = 8;             // one color channel
  localparam int PIX_W      = 3 * CH_W;      // packed source pixel
  localparam int DIV_W      = 11;            // output row/column count
  localparam int FRAC_SH    = 16;            // fraction bits of r/rows and c/cols
  localparam int Q_W        = N_W + FRAC_SH; // quotient width
  localparam int CRD_W      = 16;            // one corner coordinate
  localparam int CORNER_W   = 32;            // packed corner
  localparam int ROW_W      = 28;            // edge point after the row step
  localparam int LP1_W      = CRD_W + 1 + Q_W + 1;
  localparam int FC_LO_W    = 13;            // low part of the column fraction
  localparam int FC_HI_W    = Q_W - FC_LO_W;
  localparam int PP_W       = ROW_W + 1 + FC_LO_W + 1;
  localparam int PW2        = ROW_W + 1 + Q_W;
  localparam int POS_W      = 40;            // sample position
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOP_FIRST     = 3'd0,
    REG_TOP_SECOND    = 3'd1,
    REG_BOTTOM_SECOND = 3'd2,
    REG_BOTTOM_FIRST  = 3'd3,
    REG_OUT_ROWS      = 3'd4,
    REG_OUT_COLS      = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic            cmd;
    logic [N_W-1:0]  src_col;
    logic [N_W-1:0]  src_row;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_red;
    logic [N_W-1:0]  out_row;
    logic [N_W-1:0]  out_col;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0] res_blue;
    logic [CH_W-1:0] res_green;
    logic [CH_W-1:0] res_red;
    logic [N_W-1:0]  res_row;
    logic [N_W-1:0]  res_col;
  } result_t;

  typedef struct packed {
    logic [CORNER_W-1:0] top_first;
    logic [CORNER_W-1:0] top_second;
    logic [CORNER_W-1:0] bottom_second;
    logic [CORNER_W-1:0] bottom_first;
    logic [DIV_W-1:0]    out_rows;
    logic [DIV_W-1:0]    out_cols;
  } cfg_t;

endpackage

FILE: rtl/core/qcb_stream_if.sv
// Valid/ready stream channel carrying one word of type T.
interface qcb_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/qcb_frac_pipe.sv
// Pipelined restoring dividers for the row and column fractions.
`include "assert_macros.svh"

module qcb_frac_pipe (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  qcb_pkg::item_t            in_item,
  input  qcb_pkg::cfg_t             cfg,
  output logic                      out_valid,
  output qcb_pkg::item_t            out_item,
  output logic [qcb_pkg::Q_W-1:0]   out_fr,
  output logic [qcb_pkg::Q_W-1:0]   out_fc
);
  import qcb_pkg::*;

  localparam int CHK_W = Q_W + DIV_W;

  logic             vld  [Q_W];
  item_t            itm  [Q_W];
  logic [DIV_W-1:0] rrem [Q_W];
  logic [DIV_W-1:0] crem [Q_W];
  logic [Q_W-1:0]   rq   [Q_W];
  logic [Q_W-1:0]   cq   [Q_W];

  logic [DIV_W-1:0] dr;
  logic [DIV_W-1:0] dc;

  // Treat a zero count as one
  assign dr = (cfg.out_rows == '0) ? DIV_W'(1) : cfg.out_rows;
  assign dc = (cfg.out_cols == '0) ? DIV_W'(1) : cfg.out_cols;

  // One quotient bit per stage, most significant first
  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic             pv;
    item_t            pi;
    logic [DIV_W-1:0] pr_r, pr_c;
    logic [Q_W-1:0]   pq_r, pq_c;
    logic [Q_W-1:0]   nd_r, nd_c;
    logic [DIV_W:0]   tr, tc;
    logic [DIV_W-1:0] nr, nc;
    logic [Q_W-1:0]   nqr, nqc;

    if (s == 0) begin : g_first
      assign pv   = in_valid;
      assign pi   = in_item;
      assign pr_r = '0;
      assign pr_c = '0;
      assign pq_r = '0;
      assign pq_c = '0;
    end else begin : g_next
      assign pv   = vld[s-1];
      assign pi   = itm[s-1];
      assign pr_r = rrem[s-1];
      assign pr_c = crem[s-1];
      assign pq_r = rq[s-1];
      assign pq_c = cq[s-1];
    end

    // Shift in the next dividend bit, subtract where it fits
    always_comb begin
      nd_r = {pi.out_row, {FRAC_SH{1'b0}}};
      nd_c = {pi.out_col, {FRAC_SH{1'b0}}};
      tr   = {pr_r, nd_r[Q_W-1-s]};
      tc   = {pr_c, nd_c[Q_W-1-s]};
      if (tr >= {1'b0, dr}) begin
        nr  = DIV_W'(tr - {1'b0, dr});
        nqr = {pq_r[Q_W-2:0], 1'b1};
      end else begin
        nr  = tr[DIV_W-1:0];
        nqr = {pq_r[Q_W-2:0], 1'b0};
      end
      if (tc >= {1'b0, dc}) begin
        nc  = DIV_W'(tc - {1'b0, dc});
        nqc = {pq_c[Q_W-2:0], 1'b1};
      end else begin
        nc  = tc[DIV_W-1:0];
        nqc = {pq_c[Q_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= pv;
      end
      if (adv) begin
        itm[s]  <= pi;
        rrem[s] <= nr;
        crem[s] <= nc;
        rq[s]   <= nqr;
        cq[s]   <= nqc;
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign out_item  = itm[Q_W-1];
  assign out_fr    = rq[Q_W-1];
  assign out_fc    = cq[Q_W-1];

  // Quotient check for the row fraction
  logic [CHK_W-1:0] chk_prod;
  logic [CHK_W-1:0] chk_num;
  assign chk_prod = CHK_W'(rq[Q_W-1]) * CHK_W'(dr);
  assign chk_num  = CHK_W'({itm[Q_W-1].out_row, {FRAC_SH{1'b0}}});

  `QCB_ASSERT_IMPL(a_frac_exact, vld[Q_W-1],
    (chk_prod <= chk_num) && (chk_num < chk_prod + CHK_W'(dr)))
endmodule

FILE: rtl/core/qcb_lerp_pipe.sv
// Edge and span interpolation of the sample position, then split and clamp.
module qcb_lerp_pipe #(
  parameter int SRC_WIDTH       = 256,
  parameter int SRC_HEIGHT      = 256,
  parameter int COORD_FRAC_BITS = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  qcb_pkg::item_t                    in_item,
  input  logic [qcb_pkg::Q_W-1:0]           fr,
  input  logic [qcb_pkg::Q_W-1:0]           fc,
  input  qcb_pkg::cfg_t                     cfg,
  output logic                              out_valid,
  output qcb_pkg::item_t                    out_item,
  output logic [COORD_FRAC_BITS-1:0]        wx,
  output logic [COORD_FRAC_BITS-1:0]        wy,
  output logic [$clog2(SRC_WIDTH)-1:0]      cx0,
  output logic [$clog2(SRC_WIDTH)-1:0]      cx1,
  output logic [$clog2(SRC_HEIGHT)-1:0]     cy0,
  output logic [$clog2(SRC_HEIGHT)-1:0]     cy1
);
  import qcb_pkg::*;

  localparam int XW = $clog2(SRC_WIDTH);
  localparam int YW = $clog2(SRC_HEIGHT);
  localparam logic signed [POS_W-1:0] X_MAX = POS_W'(SRC_WIDTH - 1);
  localparam logic signed [POS_W-1:0] Y_MAX = POS_W'(SRC_HEIGHT - 1);

  // a + floor((b - a) * f / 2^16) along one corner edge
  function automatic logic signed [ROW_W-1:0] lerp_edge(
    input logic [CRD_W-1:0] a,
    input logic [CRD_W-1:0] b,
    input logic [Q_W-1:0]   f
  );
    logic signed [CRD_W:0]   d;
    logic signed [LP1_W-1:0] p;
    logic signed [LP1_W-1:0] sh;
    d  = $signed({1'b0, b}) - $signed({1'b0, a});
    p  = LP1_W'(d) * LP1_W'($signed({1'b0, f}));
    sh = p >>> FRAC_SH;
    return ROW_W'(sh) + ROW_W'($signed({1'b0, a}));
  endfunction

  // Clamp a signed index into 0..hi
  function automatic logic [N_W-1:0] clamp_idx(
    input logic signed [POS_W-1:0] v,
    input logic signed [POS_W-1:0] hi
  );
    logic [N_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > hi) begin
      r = N_W'(hi);
    end else begin
      r = N_W'(v);
    end
    return r;
  endfunction

  // Stage 1: points on the two corner edges
  logic                    v1;
  item_t                   it1;
  logic [Q_W-1:0]          fc1;
  logic signed [ROW_W-1:0] sx, sy, ex, ey;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      it1 <= in_item;
      fc1 <= fc;
      sx  <= lerp_edge(cfg.bottom_first[CRD_W-1:0], cfg.bottom_second[CRD_W-1:0], fr);
      sy  <= lerp_edge(cfg.bottom_first[CORNER_W-1:CRD_W],
                       cfg.bottom_second[CORNER_W-1:CRD_W], fr);
      ex  <= lerp_edge(cfg.top_first[CRD_W-1:0], cfg.top_second[CRD_W-1:0], fr);
      ey  <= lerp_edge(cfg.top_first[CORNER_W-1:CRD_W],
                       cfg.top_second[CORNER_W-1:CRD_W], fr);
    end
  end

  // Stage 2: span difference times the column fraction, in two halves
  logic signed [ROW_W:0]     dx, dy;
  logic signed [FC_LO_W:0]   fcl;
  logic signed [FC_HI_W:0]   fch;
  logic                      v2;
  item_t                     it2;
  logic signed [ROW_W-1:0]   sx2, sy2;
  logic signed [PP_W-1:0]    ppxl, ppxh, ppyl, ppyh;

  assign dx  = (ROW_W+1)'(ex) - (ROW_W+1)'(sx);
  assign dy  = (ROW_W+1)'(ey) - (ROW_W+1)'(sy);
  assign fcl = $signed({1'b0, fc1[FC_LO_W-1:0]});
  assign fch = $signed({1'b0, fc1[Q_W-1:FC_LO_W]});

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      it2  <= it1;
      sx2  <= sx;
      sy2  <= sy;
      ppxl <= PP_W'(dx) * PP_W'(fcl);
      ppxh <= PP_W'(dx) * PP_W'(fch);
      ppyl <= PP_W'(dy) * PP_W'(fcl);
      ppyh <= PP_W'(dy) * PP_W'(fch);
    end
  end

  // Stage 3: combine partial products and floor to position scale
  logic signed [PW2-1:0]   prx, pry;
  logic signed [PW2-1:0]   shx, shy;
  logic                    v3;
  item_t                   it3;
  logic signed [POS_W-1:0] px, py;

  assign prx = (PW2'(ppxh) <<< FC_LO_W) + PW2'(ppxl);
  assign pry = (PW2'(ppyh) <<< FC_LO_W) + PW2'(ppyl);
  assign shx = prx >>> FRAC_SH;
  assign shy = pry >>> FRAC_SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      it3 <= it2;
      px  <= POS_W'(shx) + POS_W'(sx2);
      py  <= POS_W'(shy) + POS_W'(sy2);
    end
  end

  // Stage 4: split into index and weight, clamp both neighbor indices
  logic signed [POS_W-1:0] xi, yi, xi1, yi1;
  logic                    v4;

  assign xi  = px >>> COORD_FRAC_BITS;
  assign yi  = py >>> COORD_FRAC_BITS;
  assign xi1 = xi + POS_W'(1);
  assign yi1 = yi + POS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
    if (adv) begin
      out_item <= it3;
      wx       <= px[COORD_FRAC_BITS-1:0];
      wy       <= py[COORD_FRAC_BITS-1:0];
      cx0      <= XW'(clamp_idx(xi, X_MAX));
      cx1      <= XW'(clamp_idx(xi1, X_MAX));
      cy0      <= YW'(clamp_idx(yi, Y_MAX));
      cy1      <= YW'(clamp_idx(yi1, Y_MAX));
    end
  end

  assign out_valid = v4;
endmodule

FILE: rtl/core/qcb_pix_mem.sv
// Source image in four banks split by row and column parity.
`include "assert_macros.svh"

module qcb_pix_mem #(
  parameter int SRC_WIDTH       = 256,
  parameter int SRC_HEIGHT      = 256,
  parameter int COORD_FRAC_BITS = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  qcb_pkg::item_t                    in_item,
  input  logic [COORD_FRAC_BITS-1:0]        in_wx,
  input  logic [COORD_FRAC_BITS-1:0]        in_wy,
  input  logic [$clog2(SRC_WIDTH)-1:0]      cx0,
  input  logic [$clog2(SRC_WIDTH)-1:0]      cx1,
  input  logic [$clog2(SRC_HEIGHT)-1:0]     cy0,
  input  logic [$clog2(SRC_HEIGHT)-1:0]     cy1,
  output logic                              out_valid,
  output qcb_pkg::item_t                    out_item,
  output logic [COORD_FRAC_BITS-1:0]        wx,
  output logic [COORD_FRAC_BITS-1:0]        wy,
  output logic [qcb_pkg::PIX_W-1:0]         p00,
  output logic [qcb_pkg::PIX_W-1:0]         p01,
  output logic [qcb_pkg::PIX_W-1:0]         p10,
  output logic [qcb_pkg::PIX_W-1:0]         p11
);
  import qcb_pkg::*;

  localparam int XW  = $clog2(SRC_WIDTH);
  localparam int YW  = $clog2(SRC_HEIGHT);
  localparam int HW  = (SRC_WIDTH + 1) / 2;
  localparam int HH  = (SRC_HEIGHT + 1) / 2;
  localparam int BD  = HW * HH;
  localparam int AW  = (BD > 1) ? $clog2(BD) : 1;
  localparam int AXW = AW + XW + YW;

  // Address inside a bank: half row times half width plus half column
  function automatic logic [AW-1:0] bank_addr(
    input logic [XW-1:0] c,
    input logic [YW-1:0] r
  );
    logic [AXW-1:0] t;
    t = AXW'((AXW'(r) >> 1) * AXW'(HW)) + (AXW'(c) >> 1);
    return t[AW-1:0];
  endfunction

  logic              wr_ok;
  logic [PIX_W-1:0]  wdata;
  logic [AW-1:0]     waddr;
  logic [PIX_W-1:0]  bank_q [4];

  // Drop writes outside the image
  assign wr_ok = adv && in_valid && (in_item.cmd == CMD_WRITE) &&
                 (32'(in_item.src_col) < SRC_WIDTH) &&
                 (32'(in_item.src_row) < SRC_HEIGHT);
  assign wdata = {in_item.in_red, in_item.in_green, in_item.in_blue};
  assign waddr = bank_addr(in_item.src_col[XW-1:0], in_item.src_row[YW-1:0]);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam bit PX = (b % 2) == 1;
    localparam bit PY = (b / 2) == 1;

    logic [PIX_W-1:0] mem [BD];
    logic [XW-1:0]    colsel;
    logic [YW-1:0]    rowsel;
    logic [AW-1:0]    raddr;
    logic             we;
    logic [PIX_W-1:0] rd;

    // Pick the neighbor index whose parity matches this bank
    assign colsel = (cx0[0] == PX) ? cx0 : cx1;
    assign rowsel = (cy0[0] == PY) ? cy0 : cy1;
    assign raddr  = bank_addr(colsel, rowsel);
    assign we     = wr_ok && (in_item.src_col[0] == PX) && (in_item.src_row[0] == PY);

    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      if (adv) begin
        rd <= mem[raddr];
      end
    end

    assign bank_q[b] = rd;
  end

  // Carry the item and tap parities next to the read data
  logic x0p, x1p, y0p, y1p;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
    if (adv) begin
      out_item <= in_item;
      wx       <= in_wx;
      wy       <= in_wy;
      x0p      <= cx0[0];
      x1p      <= cx1[0];
      y0p      <= cy0[0];
      y1p      <= cy1[0];
    end
  end

  assign p00 = bank_q[{y0p, x0p}];
  assign p01 = bank_q[{y1p, x0p}];
  assign p10 = bank_q[{y0p, x1p}];
  assign p11 = bank_q[{y1p, x1p}];

  `QCB_ASSERT_IMPL(a_mem_cols, in_valid, (cx1 == cx0) || (cx1 == cx0 + 1'b1))
  `QCB_ASSERT_IMPL(a_mem_rows, in_valid, (cy1 == cy0) || (cy1 == cy0 + 1'b1))
endmodule

FILE: rtl/core/qcb_blend.sv
// Bilinear weighting of four taps, rounding and saturation into the output word.
module qcb_blend #(
  parameter int COORD_FRAC_BITS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  qcb_pkg::item_t                in_item,
  input  logic [COORD_FRAC_BITS-1:0]    wx,
  input  logic [COORD_FRAC_BITS-1:0]    wy,
  input  logic [qcb_pkg::PIX_W-1:0]     p00,
  input  logic [qcb_pkg::PIX_W-1:0]     p01,
  input  logic [qcb_pkg::PIX_W-1:0]     p10,
  input  logic [qcb_pkg::PIX_W-1:0]     p11,
  output logic                          out_valid,
  output qcb_pkg::result_t              out_res
);
  import qcb_pkg::*;

  localparam int F     = COORD_FRAC_BITS;
  localparam int W1    = F + 1;
  localparam int LO_W  = F + CH_W;
  localparam int TOT_W = 2 * F + CH_W;
  localparam logic [W1-1:0]  ONE = W1'(1) << F;
  localparam logic [TOT_W:0] RND = (TOT_W+1)'(1) << (2 * F - 1);
  localparam logic [TOT_W:0] SAT = (TOT_W+1)'(255);

  logic [W1-1:0] omy, omx1;

  assign omy = ONE - W1'(wy);

  // Stage 1: interpolate along y at both columns
  logic                v1;
  item_t               it1;
  logic [F-1:0]        wx1;
  logic [LO_W-1:0]     lo [3];
  logic [LO_W-1:0]     hi [3];

  // Stage 2: interpolate along x
  logic                v2;
  item_t               it2;
  logic [TOT_W-1:0]    tot [3];

  // Stage 3: round half up, saturate
  logic [CH_W-1:0]     ch_res [3];

  assign omx1 = ONE - W1'(wx1);

  for (genvar k = 0; k < 3; k++) begin : g_chan
    logic [CH_W-1:0] a, bb, c, d;
    logic [TOT_W:0]  rnd;
    logic [TOT_W:0]  sh;

    assign a  = p00[k*CH_W +: CH_W];
    assign bb = p01[k*CH_W +: CH_W];
    assign c  = p10[k*CH_W +: CH_W];
    assign d  = p11[k*CH_W +: CH_W];

    always_ff @(posedge clk) begin
      if (adv) begin
        lo[k]  <= LO_W'(LO_W'(omy) * LO_W'(a) + LO_W'(wy) * LO_W'(bb));
        hi[k]  <= LO_W'(LO_W'(omy) * LO_W'(c) + LO_W'(wy) * LO_W'(d));
        tot[k] <= TOT_W'(TOT_W'(omx1) * TOT_W'(lo[k]) + TOT_W'(wx1) * TOT_W'(hi[k]));
      end
    end

    assign rnd = (TOT_W+1)'(tot[k]) + RND;
    assign sh  = rnd >> (2 * F);
    assign ch_res[k] = (sh > SAT) ? CH_W'(255) : sh[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2 && (it2.cmd == CMD_SAMPLE);
    end
    if (adv) begin
      it1               <= in_item;
      wx1               <= wx;
      it2               <= it1;
      out_res.res_blue  <= ch_res[0];
      out_res.res_green <= ch_res[1];
      out_res.res_red   <= ch_res[2];
      out_res.res_row   <= it2.out_row;
      out_res.res_col   <= it2.out_col;
    end
  end
endmodule

FILE: rtl/core/quad_crop_bilinear_resampler_unit.sv
// Top level of the quad crop bilinear resampler.
//
// Channel req takes one word per item: cmd 0 writes one source pixel
// (src_col, src_row, blue, green, red; writes outside the image are dropped),
// cmd 1 samples output pixel (out_row, out_col) of the crop given by the four
// corner registers and the out_rows/out_cols counts. Channel rsp returns one
// word per sample with rounded B, G, R and the echoed row and column; writes
// return nothing. Words leave in the order they arrived.
// The pipeline has 34 register stages: 26 divider stages (one quotient bit
// each for r/out_rows and c/out_cols), 4 interpolation stages, 1 registered
// read of the four parity banks and 3 blend stages. Throughput is one word
// per cycle while rsp is not stalled: the four banks give all four taps of a
// sample in a single read. A source write lands when it reaches the bank
// stage, ahead of every later sample.
// Reset clears all valid bits and loads the register defaults (corners 0,
// counts 64); the image holds whatever it held until written, with no clearing.
// When rsp is stalled the whole pipeline holds and req.ready drops in the
// same cycle; nothing is lost or repeated.
// Configuration: cfg_we with cfg_index and cfg_wdata, written while idle.
`include "assert_macros.svh"

module quad_crop_bilinear_resampler_unit #(
  parameter int SRC_WIDTH       = 256,
  parameter int SRC_HEIGHT      = 256,
  parameter int COORD_FRAC_BITS = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  qcb_stream_if.sink                        req,
  qcb_stream_if.source                      rsp,
  input  logic                              cfg_we,
  input  logic [qcb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qcb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import qcb_pkg::*;

  localparam int XW = $clog2(SRC_WIDTH);
  localparam int YW = $clog2(SRC_HEIGHT);

  cfg_t cfg;
  logic adv;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.top_first     <= '0;
      cfg.top_second    <= '0;
      cfg.bottom_second <= '0;
      cfg.bottom_first  <= '0;
      cfg.out_rows      <= DIV_W'(64);
      cfg.out_cols      <= DIV_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOP_FIRST:     cfg.top_first     <= cfg_wdata;
        REG_TOP_SECOND:    cfg.top_second    <= cfg_wdata;
        REG_BOTTOM_SECOND: cfg.bottom_second <= cfg_wdata;
        REG_BOTTOM_FIRST:  cfg.bottom_first  <= cfg_wdata;
        REG_OUT_ROWS:      cfg.out_rows      <= cfg_wdata[DIV_W-1:0];
        REG_OUT_COLS:      cfg.out_cols      <= cfg_wdata[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless the output word is stalled
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  logic                 f_valid;
  item_t                f_item;
  logic [Q_W-1:0]       f_fr, f_fc;

  qcb_frac_pipe u_frac (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (req.valid),
    .in_item   (req.data),
    .cfg       (cfg),
    .out_valid (f_valid),
    .out_item  (f_item),
    .out_fr    (f_fr),
    .out_fc    (f_fc)
  );

  logic                        l_valid;
  item_t                       l_item;
  logic [COORD_FRAC_BITS-1:0]  l_wx, l_wy;
  logic [XW-1:0]               l_cx0, l_cx1;
  logic [YW-1:0]               l_cy0, l_cy1;

  qcb_lerp_pipe #(
    .SRC_WIDTH       (SRC_WIDTH),
    .SRC_HEIGHT      (SRC_HEIGHT),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_lerp (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_item   (f_item),
    .fr        (f_fr),
    .fc        (f_fc),
    .cfg       (cfg),
    .out_valid (l_valid),
    .out_item  (l_item),
    .wx        (l_wx),
    .wy        (l_wy),
    .cx0       (l_cx0),
    .cx1       (l_cx1),
    .cy0       (l_cy0),
    .cy1       (l_cy1)
  );

  logic                        m_valid;
  item_t                       m_item;
  logic [COORD_FRAC_BITS-1:0]  m_wx, m_wy;
  logic [PIX_W-1:0]            m_p00, m_p01, m_p10, m_p11;

  qcb_pix_mem #(
    .SRC_WIDTH       (SRC_WIDTH),
    .SRC_HEIGHT      (SRC_HEIGHT),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_mem (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (l_valid),
    .in_item   (l_item),
    .in_wx     (l_wx),
    .in_wy     (l_wy),
    .cx0       (l_cx0),
    .cx1       (l_cx1),
    .cy0       (l_cy0),
    .cy1       (l_cy1),
    .out_valid (m_valid),
    .out_item  (m_item),
    .wx        (m_wx),
    .wy        (m_wy),
    .p00       (m_p00),
    .p01       (m_p01),
    .p10       (m_p10),
    .p11       (m_p11)
  );

  logic    b_valid;
  result_t b_res;

  qcb_blend #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_blend (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (m_valid),
    .in_item   (m_item),
    .wx        (m_wx),
    .wy        (m_wy),
    .p00       (m_p00),
    .p01       (m_p01),
    .p10       (m_p10),
    .p11       (m_p11),
    .out_valid (b_valid),
    .out_res   (b_res)
  );

  assign rsp.valid = b_valid;
  assign rsp.data  = b_res;

  `QCB_ASSERT_IMPL(a_top_stall, rsp.valid && !rsp.ready, !req.ready)
endmodule
